// ----- rtl/clpg_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and the pen colour table of the line pixel generator
// depends on nothing

package clpg_pkg;

    localparam int DEFAULT_COORD_BITS     = 16;
    localparam int DEFAULT_MAX_RASTER_DIM = 16384;

    localparam int CFG_BITS    = 15;
    localparam int ADDR_BITS   = 28;
    localparam int COLOUR_BITS = 8;
    localparam int PADDR_BITS  = 3;
    localparam int PDATA_BITS  = 32;

    localparam logic [CFG_BITS-1:0] RASTER_RESET = 15'd1024;

    // register indexes, taken from paddr[2]
    localparam logic REG_RASTER_WIDTH  = 1'b0;
    localparam logic REG_RASTER_HEIGHT = 1'b1;

    // request opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [COLOUR_BITS-1:0] FULL = 8'd255;
    localparam logic [COLOUR_BITS-1:0] NONE = 8'd0;
    // 0.95 of full scale, truncated
    localparam logic [COLOUR_BITS-1:0] PEN_RED_LEVEL  = 8'd242;
    // 0.6 of full scale
    localparam logic [COLOUR_BITS-1:0] PEN_GREY_LEVEL = 8'd153;

    typedef struct packed {
        logic [COLOUR_BITS-1:0] red;
        logic [COLOUR_BITS-1:0] green;
        logic [COLOUR_BITS-1:0] blue;
    } rgb_t;

    function automatic rgb_t pen_colour(input logic [3:0] pen);
        rgb_t c;
        case (pen)
            4'd1:    c = '{NONE, FULL, FULL};
            4'd3:    c = '{NONE, FULL, NONE};
            4'd4:    c = '{FULL, FULL, NONE};
            4'd5:    c = '{FULL, NONE, FULL};
            4'd6:    c = '{NONE, NONE, FULL};
            4'd7:    c = '{PEN_RED_LEVEL, NONE, NONE};
            4'd8:    c = '{PEN_GREY_LEVEL, PEN_GREY_LEVEL, PEN_GREY_LEVEL};
            default: c = '{NONE, NONE, NONE};
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/clipped_line_pixel_generator_unit.sv -----
`timescale 1ns / 1ps
// clipped line pixel generator: all-octant bresenham stepping, clipping and addressing
// depends on clpg_pkg
//
// usage: a request with opcode 0 loads a line (start and end point, pen) and yields
// the start pixel; each request with opcode 1 yields the next pixel of the line.
// the pixel on the end point has line_done set and ends the line. a step with no
// line loaded yields an all-zero pixel with line_done set. pixels outside the raster
// come out with pixel_valid low and a zero address.
// input channel: in_valid / in_stall, output channel: out_valid / out_stall.
// the raster size must be written over the apb port only while the block is idle;
// the block does not enforce this. a result passes the stepping stage, then the clip,
// address multiply and colour stage. throughput: one pixel per cycle while the
// receiver does not stall, set by the single error-term update in the stepping stage.
// when the receiver stalls a valid pixel the whole pipe holds and in_stall is raised.
// reset clears the line state, empties the pipe and sets the raster to 1024 x 1024.

module clipped_line_pixel_generator_unit #(
    parameter int COORD_BITS     = clpg_pkg::DEFAULT_COORD_BITS,
    parameter int MAX_RASTER_DIM = clpg_pkg::DEFAULT_MAX_RASTER_DIM
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // apb configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [clpg_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [clpg_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [clpg_pkg::PDATA_BITS-1:0]     prdata,
    output logic                                pready,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                opcode,
    input  logic signed [COORD_BITS-1:0]        start_x,
    input  logic signed [COORD_BITS-1:0]        start_y,
    input  logic signed [COORD_BITS-1:0]        end_x,
    input  logic signed [COORD_BITS-1:0]        end_y,
    input  logic [3:0]                          pen_number,
    // pixel channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                pixel_valid,
    output logic signed [COORD_BITS-1:0]        pixel_x,
    output logic signed [COORD_BITS-1:0]        pixel_y,
    output logic [clpg_pkg::ADDR_BITS-1:0]      pixel_address,
    output logic [clpg_pkg::COLOUR_BITS-1:0]    red,
    output logic [clpg_pkg::COLOUR_BITS-1:0]    green,
    output logic [clpg_pkg::COLOUR_BITS-1:0]    blue,
    output logic                                line_done
);

    localparam int CW   = COORD_BITS;
    localparam int FB   = clpg_pkg::CFG_BITS;
    localparam int CMPW = ((CW > FB) ? CW : FB) + 1;
    localparam int PW   = CMPW + FB;

    // configuration
    logic [FB-1:0] width_reg;
    logic [FB-1:0] height_reg;
    logic          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= clpg_pkg::RASTER_RESET;
            height_reg <= clpg_pkg::RASTER_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                clpg_pkg::REG_RASTER_WIDTH:  width_reg  <= pwdata[FB-1:0];
                clpg_pkg::REG_RASTER_HEIGHT: height_reg <= pwdata[FB-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            clpg_pkg::REG_RASTER_WIDTH:  prdata = clpg_pkg::PDATA_BITS'(width_reg);
            clpg_pkg::REG_RASTER_HEIGHT: prdata = clpg_pkg::PDATA_BITS'(height_reg);
            default:                     prdata = '0;
        endcase
    end

    // pipe control
    logic advance;
    logic in_accept;
    logic s1_valid_reg;
    logic out_valid_reg;

    assign advance   = !(out_valid_reg && out_stall);
    assign in_stall  = !advance;
    assign in_accept = in_valid && advance;
    assign out_valid = out_valid_reg;

    // line state
    logic                  line_active_reg, line_active_next;
    logic signed [CW-1:0]  cur_x_reg, cur_x_next;
    logic signed [CW-1:0]  cur_y_reg, cur_y_next;
    logic signed [CW-1:0]  tgt_x_reg, tgt_x_next;
    logic signed [CW-1:0]  tgt_y_reg, tgt_y_next;
    logic                  neg_x_reg, neg_x_next;
    logic                  neg_y_reg, neg_y_next;
    // magnitude, unsigned, at most 2**CW - 1
    logic [CW:0]           dx_reg, dx_next;
    logic signed [CW+1:0]  dyn_reg, dyn_next;
    logic signed [CW+2:0]  err_reg, err_next;
    logic [3:0]            pen_reg, pen_next;
    logic                  done_next;
    logic                  idle_next;

    logic signed [CW:0]    diff_x, diff_y;
    logic [CW:0]           abs_x, abs_y;
    logic signed [CW+3:0]  e2;
    logic                  move_x, move_y;

    always_comb
    begin
        line_active_next = line_active_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        tgt_x_next = tgt_x_reg;
        tgt_y_next = tgt_y_reg;
        neg_x_next = neg_x_reg;
        neg_y_next = neg_y_reg;
        dx_next    = dx_reg;
        dyn_next   = dyn_reg;
        err_next   = err_reg;
        pen_next   = pen_reg;
        idle_next  = 1'b0;
        done_next  = 1'b1;

        diff_x = (CW+1)'(end_x) - (CW+1)'(start_x);
        diff_y = (CW+1)'(end_y) - (CW+1)'(start_y);
        abs_x  = diff_x[CW] ? -diff_x : diff_x;
        abs_y  = diff_y[CW] ? -diff_y : diff_y;
        e2     = (CW+4)'(err_reg) <<< 1;
        move_x = e2 >= (CW+4)'(dyn_reg);
        move_y = e2 <= $signed((CW+4)'(dx_reg));

        if (opcode == clpg_pkg::OP_START)
        begin
            cur_x_next = start_x;
            cur_y_next = start_y;
            tgt_x_next = end_x;
            tgt_y_next = end_y;
            neg_x_next = !(start_x < end_x);
            neg_y_next = !(start_y < end_y);
            dx_next    = abs_x;
            dyn_next   = -((CW+2)'(abs_y));
            err_next   = (CW+3)'(abs_x) - (CW+3)'(abs_y);
            pen_next   = pen_number;
            done_next  = (start_x == end_x) && (start_y == end_y);
            line_active_next = !done_next;
        end
        else if (!line_active_reg)
        begin
            idle_next = 1'b1;
        end
        else
        begin
            err_next = err_reg + (move_x ? (CW+3)'(dyn_reg) : '0)
                               + (move_y ? (CW+3)'(dx_reg) : '0);
            if (move_x)
            begin
                cur_x_next = neg_x_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
            end
            if (move_y)
            begin
                cur_y_next = neg_y_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
            end
            done_next = (cur_x_next == tgt_x_reg) && (cur_y_next == tgt_y_reg);
            line_active_next = !done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            tgt_x_reg <= '0;
            tgt_y_reg <= '0;
            neg_x_reg <= 1'b0;
            neg_y_reg <= 1'b0;
            dx_reg    <= '0;
            dyn_reg   <= '0;
            err_reg   <= '0;
            pen_reg   <= '0;
        end
        else if (in_accept)
        begin
            line_active_reg <= line_active_next;
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            tgt_x_reg <= tgt_x_next;
            tgt_y_reg <= tgt_y_next;
            neg_x_reg <= neg_x_next;
            neg_y_reg <= neg_y_next;
            dx_reg    <= dx_next;
            dyn_reg   <= dyn_next;
            err_reg   <= err_next;
            pen_reg   <= pen_next;
        end
    end

    // stage one result
    logic signed [CW-1:0] s1_x_reg, s1_y_reg;
    logic [3:0]           s1_pen_reg;
    logic                 s1_done_reg;
    logic                 s1_idle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= in_accept;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_x_reg    <= cur_x_next;
            s1_y_reg    <= cur_y_next;
            s1_pen_reg  <= pen_next;
            s1_done_reg <= done_next;
            s1_idle_reg <= idle_next;
        end
    end

    // stage two: clipping, address and colour
    logic [FB-1:0]     w_eff, h_eff;
    logic [CMPW-1:0]   x_ext, y_ext;
    logic              in_raster;
    logic [PW-1:0]     addr_full;
    clpg_pkg::rgb_t    colour;

    always_comb
    begin
        w_eff = (32'(width_reg) > 32'(MAX_RASTER_DIM)) ? FB'(MAX_RASTER_DIM) : width_reg;
        h_eff = (32'(height_reg) > 32'(MAX_RASTER_DIM)) ? FB'(MAX_RASTER_DIM) : height_reg;
        x_ext = CMPW'($unsigned(s1_x_reg));
        y_ext = CMPW'($unsigned(s1_y_reg));
        in_raster = !s1_x_reg[CW-1] && !s1_y_reg[CW-1]
                    && (x_ext < CMPW'(w_eff)) && (y_ext < CMPW'(h_eff));
        addr_full = PW'(y_ext) * PW'(w_eff) + PW'(x_ext);
        colour = clpg_pkg::pen_colour(s1_pen_reg);
    end

    logic                               pixel_valid_reg;
    logic signed [CW-1:0]               pixel_x_reg, pixel_y_reg;
    logic [clpg_pkg::ADDR_BITS-1:0]     pixel_address_reg;
    clpg_pkg::rgb_t                     colour_reg;
    logic                               line_done_reg;

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            if (s1_idle_reg)
            begin
                pixel_valid_reg   <= 1'b0;
                pixel_x_reg       <= '0;
                pixel_y_reg       <= '0;
                pixel_address_reg <= '0;
                colour_reg        <= '0;
                line_done_reg     <= 1'b1;
            end
            else
            begin
                pixel_valid_reg   <= in_raster;
                pixel_x_reg       <= s1_x_reg;
                pixel_y_reg       <= s1_y_reg;
                pixel_address_reg <= in_raster ? addr_full[clpg_pkg::ADDR_BITS-1:0] : '0;
                colour_reg        <= colour;
                line_done_reg     <= s1_done_reg;
            end
        end
    end

    assign pixel_valid   = pixel_valid_reg;
    assign pixel_x       = pixel_x_reg;
    assign pixel_y       = pixel_y_reg;
    assign pixel_address = pixel_address_reg;
    assign red           = colour_reg.red;
    assign green         = colour_reg.green;
    assign blue          = colour_reg.blue;
    assign line_done     = line_done_reg;

endmodule

// ----- bench/clipped_line_pixel_generator_unit_tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for the clipped line pixel generator: queued line and step
// requests, an in-bench line stepper with clipping and pen colours, bursty sender
// and stalling receiver; depends on clpg_pkg and clipped_line_pixel_generator_unit

module clipped_line_pixel_generator_unit_tb;

    localparam int   MAX_DIM  = clpg_pkg::DEFAULT_MAX_RASTER_DIM;
    localparam int   PHASES   = 8;
    localparam int   PHASE_ITEMS = 97;
    localparam int   HOLD_CYCLES = 60;

    typedef struct packed {
        logic        op;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] ex;
        logic [15:0] ey;
        logic [3:0]  pen;
    } req_t;

    typedef struct packed {
        logic                             in_raster;
        logic [15:0]                      x;
        logic [15:0]                      y;
        logic [clpg_pkg::ADDR_BITS-1:0]   addr;
        logic [clpg_pkg::COLOUR_BITS-1:0] red;
        logic [clpg_pkg::COLOUR_BITS-1:0] green;
        logic [clpg_pkg::COLOUR_BITS-1:0] blue;
        logic                             done;
    } pixel_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [clpg_pkg::PADDR_BITS-1:0]  paddr = '0;
    logic [clpg_pkg::PDATA_BITS-1:0]  pwdata = '0;
    logic [clpg_pkg::PDATA_BITS-1:0]  prdata;
    logic                             pready;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic                             opcode = 1'b0;
    logic signed [15:0]               start_x = '0;
    logic signed [15:0]               start_y = '0;
    logic signed [15:0]               end_x = '0;
    logic signed [15:0]               end_y = '0;
    logic [3:0]                       pen_number = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic                             pixel_valid;
    logic signed [15:0]               pixel_x;
    logic signed [15:0]               pixel_y;
    logic [clpg_pkg::ADDR_BITS-1:0]   pixel_address;
    logic [clpg_pkg::COLOUR_BITS-1:0] red;
    logic [clpg_pkg::COLOUR_BITS-1:0] green;
    logic [clpg_pkg::COLOUR_BITS-1:0] blue;
    logic                             line_done;

    clipped_line_pixel_generator_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .pen_number    (pen_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_valid   (pixel_valid),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_address (pixel_address),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .line_done     (line_done)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // line stepper state and raster size as the block should hold them
    logic [clpg_pkg::CFG_BITS-1:0] width_reg = clpg_pkg::RASTER_RESET;
    logic [clpg_pkg::CFG_BITS-1:0] height_reg = clpg_pkg::RASTER_RESET;
    logic                line_on = 1'b0;
    int                  cur_x = 0;
    int                  cur_y = 0;
    int                  tgt_x = 0;
    int                  tgt_y = 0;
    logic                go_left = 1'b0;
    logic                go_up = 1'b0;
    int                  run_x = 0;
    int                  rise_neg = 0;
    int                  err_acc = 0;
    logic [3:0]          line_pen = '0;

    req_t   pending_requests[$];
    pixel_t expected_pixels[$];

    int unsigned queued_items = 0;
    int unsigned accepted_requests = 0;
    int unsigned line_starts = 0;
    int unsigned idle_steps = 0;
    int unsigned pixels_checked = 0;
    int unsigned clipped_pixels = 0;
    int unsigned in_stall_cycles = 0;
    int unsigned failures = 0;

    int unsigned stall_pct = 0;
    int unsigned gap_max = 0;
    logic        hold_request = 1'b0;
    int unsigned hold_left = 0;
    int unsigned gap_left = 0;
    int unsigned burst_left = 1;
    logic        req_fire = 1'b0;

    function automatic logic [23:0] pen_rgb(input logic [3:0] p);
        case (p)
            4'd1:    return {8'd0, 8'd255, 8'd255};
            4'd3:    return {8'd0, 8'd255, 8'd0};
            4'd4:    return {8'd255, 8'd255, 8'd0};
            4'd5:    return {8'd255, 8'd0, 8'd255};
            4'd6:    return {8'd0, 8'd0, 8'd255};
            4'd7:    return {8'd242, 8'd0, 8'd0};
            4'd8:    return {8'd153, 8'd153, 8'd153};
            default: return 24'd0;
        endcase
    endfunction

    function automatic int eff_dim(input int unsigned v);
        return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    function automatic pixel_t rasterise_request(input req_t r);
        pixel_t      p;
        int          e2;
        int          ew;
        int          eh;
        logic [23:0] rgb;
        p = '0;
        if (r.op == clpg_pkg::OP_START)
        begin
            cur_x = $signed(r.sx);
            cur_y = $signed(r.sy);
            tgt_x = $signed(r.ex);
            tgt_y = $signed(r.ey);
            go_left = !(cur_x < tgt_x);
            go_up = !(cur_y < tgt_y);
            run_x = (tgt_x > cur_x) ? tgt_x - cur_x : cur_x - tgt_x;
            rise_neg = -((tgt_y > cur_y) ? tgt_y - cur_y : cur_y - tgt_y);
            err_acc = run_x + rise_neg;
            line_pen = r.pen;
        end
        else if (!line_on)
        begin
            p.done = 1'b1;
            return p;
        end
        else
        begin
            e2 = 2 * err_acc;
            if (e2 >= rise_neg)
            begin
                err_acc += rise_neg;
                cur_x += go_left ? -1 : 1;
            end
            if (e2 <= run_x)
            begin
                err_acc += run_x;
                cur_y += go_up ? -1 : 1;
            end
        end
        p.done = (cur_x == tgt_x) && (cur_y == tgt_y);
        line_on = !p.done;
        ew = eff_dim(width_reg);
        eh = eff_dim(height_reg);
        p.in_raster = cur_x >= 0 && cur_y >= 0 && cur_x < ew && cur_y < eh;
        p.x = cur_x[15:0];
        p.y = cur_y[15:0];
        p.addr = p.in_raster ? clpg_pkg::ADDR_BITS'(cur_y * ew + cur_x) : '0;
        rgb = pen_rgb(line_pen);
        p.red = rgb[23:16];
        p.green = rgb[15:8];
        p.blue = rgb[7:0];
        return p;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    // predict on each accepted request, compare each accepted pixel
    always @(posedge clk)
    begin
        req_t   r;
        pixel_t want;
        req_fire = rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == clpg_pkg::REG_RASTER_WIDTH)
                    width_reg = pwdata[clpg_pkg::CFG_BITS-1:0];
                else
                    height_reg = pwdata[clpg_pkg::CFG_BITS-1:0];
            end
            if (in_valid && in_stall)
                in_stall_cycles++;
            if (req_fire)
            begin
                r = '{opcode, start_x, start_y, end_x, end_y, pen_number};
                accepted_requests++;
                if (r.op == clpg_pkg::OP_START)
                    line_starts++;
                else if (!line_on)
                    idle_steps++;
                expected_pixels.push_back(rasterise_request(r));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel with no request outstanding: x 0x%0h y 0x%0h",
                           pixel_x, pixel_y);
                    failures++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    pixels_checked++;
                    if (!want.in_raster)
                        clipped_pixels++;
                    check_field("pixel_valid", want.in_raster, pixel_valid);
                    check_field("pixel_x", want.x, $unsigned(pixel_x));
                    check_field("pixel_y", want.y, $unsigned(pixel_y));
                    check_field("pixel_address", want.addr, pixel_address);
                    check_field("red", want.red, red);
                    check_field("green", want.green, green);
                    check_field("blue", want.blue, blue);
                    check_field("line_done", want.done, line_done);
                end
            end
        end
    end

    // request sender: bursts with random gaps
    always @(negedge clk)
    begin
        req_t r;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || req_fire)
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (pending_requests.size() == 0)
                in_valid <= 1'b0;
            else
            begin
                r = pending_requests.pop_front();
                in_valid <= 1'b1;
                opcode <= r.op;
                start_x <= r.sx;
                start_y <= r.sy;
                end_x <= r.ex;
                end_y <= r.ey;
                pen_number <= r.pen;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                end
                else
                    burst_left--;
            end
        end
    end

    // pixel receiver: random stalls plus occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic push_request(input logic op, input int sx, input int sy, input int ex,
                                input int ey, input int pen);
        req_t r;
        r.op = op;
        r.sx = sx[15:0];
        r.sy = sy[15:0];
        r.ex = ex[15:0];
        r.ey = ey[15:0];
        r.pen = pen[3:0];
        pending_requests.push_back(r);
        queued_items++;
    endtask

    task automatic push_steps(input int n);
        repeat (n)
            push_request(clpg_pkg::OP_STEP, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
    endtask

    function automatic int full_steps(input int sx, input int sy, input int ex, input int ey);
        int ax;
        int ay;
        ax = (ex > sx) ? ex - sx : sx - ex;
        ay = (ey > sy) ? ey - sy : sy - ey;
        return (ax > ay) ? ax : ay;
    endfunction

    task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
                             input int pen, input int n);
        push_request(clpg_pkg::OP_START, sx, sy, ex, ey, pen);
        push_steps(n);
    endtask

    function automatic int clamp16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int rand16();
        return $signed(16'($urandom));
    endfunction

    task automatic fill_phase(input int ew, input int eh, input int unsigned goal);
        int mode;
        int sx;
        int sy;
        int ex;
        int ey;
        int reach;
        int n;
        while (queued_items < goal)
        begin
            mode = $urandom_range(0, 99);
            reach = ($urandom_range(0, 9) == 0) ? 40 : 12;
            if (mode < 70)
            begin
                // well-formed line around the raster, sometimes stepped past its end
                sx = clamp16($urandom_range(0, ew + 6) - 3);
                sy = clamp16($urandom_range(0, eh + 6) - 3);
                ex = clamp16(sx + $urandom_range(0, 2 * reach) - reach);
                ey = clamp16(sy + $urandom_range(0, 2 * reach) - reach);
                n = full_steps(sx, sy, ex, ey);
                if ($urandom_range(0, 3) == 0)
                    n += $urandom_range(1, 2);
                draw_line(sx, sy, ex, ey, $urandom_range(0, 15), n);
            end
            else if (mode < 85)
            begin
                sx = rand16();
                sy = rand16();
                ex = clamp16(sx + $urandom_range(0, 2 * reach) - reach);
                ey = clamp16(sy + $urandom_range(0, 2 * reach) - reach);
                n = full_steps(sx, sy, ex, ey);
                if (n > 0 && $urandom_range(0, 1) == 0)
                    n = $urandom_range(0, n - 1);
                draw_line(sx, sy, ex, ey, $urandom_range(0, 15), n);
            end
            else if (mode < 93)
                draw_line(rand16(), rand16(), rand16(), rand16(), $urandom_range(0, 15),
                          $urandom_range(1, 4));
            else
                push_steps($urandom_range(1, 3));
        end
    endtask

    task automatic drain_pipe();
        while (pending_requests.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic idx, input int unsigned value);
        logic [clpg_pkg::PDATA_BITS-1:0] data;
        data = $urandom;
        data[clpg_pkg::CFG_BITS-1:0] = value[clpg_pkg::CFG_BITS-1:0];
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial
    begin
        int unsigned widths[PHASES];
        int unsigned heights[PHASES];
        int unsigned stalls[PHASES];
        int unsigned gaps[PHASES];
        widths  = '{1024, 16384, 1, 0, 32767, 24, 16384, 0};
        heights = '{1024, 16384, 1, 32767, 0, 16, 1, 0};
        stalls  = '{0, 30, 60, 20, 0, 45, 10, 70};
        gaps    = '{4, 0, 8, 2, 0, 6, 3, 10};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                drain_pipe();
                if (ph == PHASES - 1)
                begin
                    widths[ph] = $urandom_range(1, 64);
                    heights[ph] = $urandom_range(1, 64);
                end
                apb_write(clpg_pkg::REG_RASTER_WIDTH, widths[ph]);
                apb_write(clpg_pkg::REG_RASTER_HEIGHT, heights[ph]);
            end
            stall_pct = stalls[ph];
            gap_max = gaps[ph];
            if (ph == 2 || ph == 5)
                hold_request = 1'b1;
            if (ph == 0)
            begin
                // step with no line, degenerate line, then a step past it
                push_steps(1);
                draw_line(5, 5, 5, 5, 1, 1);
                // full-range diagonals, each cut short by the next start
                draw_line(-32768, -32768, 32767, 32767, 15, 2);
                draw_line(32767, -32768, -32768, 32767, 0, 1);
                // crossing the right, left and top raster edges, then a line inside the raster
                draw_line(1020, 1020, 1027, 1023, 8, 7);
                draw_line(3, -2, -1, 2, 7, 4);
                draw_line(0, 0, 2, 6, 4, 6);
            end
            else
                fill_phase(eff_dim(widths[ph]), eff_dim(heights[ph]),
                           queued_items + PHASE_ITEMS);
        end
        drain_pipe();
        repeat (8) @(posedge clk);
        $display("covered %0d requests (%0d line starts, %0d idle steps) over %0d raster sizes",
                 accepted_requests, line_starts, idle_steps, PHASES);
        $display("checked %0d pixels, %0d clipped; input stalled for %0d cycles",
                 pixels_checked, clipped_pixels, in_stall_cycles);
        if (failures == 0)
            $display("clipped_line_pixel_generator_unit_tb: PASS");
        else
            $display("clipped_line_pixel_generator_unit_tb: FAIL");
        $finish;
    end

    initial
    begin
        #400000;
        $display("timeout with %0d pixels outstanding", expected_pixels.size());
        $display("clipped_line_pixel_generator_unit_tb: FAIL");
        $finish;
    end

endmodule
